[rtl/fsp_pkg.sv]
// Shared types, constants and helper functions for the format specifier parser.
// Depends on nothing; fsp_step and the top level refer to it by scoped names.
package fsp_pkg;

  localparam logic [30:0] SAT31   = 31'h7FFF_FFFF;
  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Characters with a meaning of their own inside a specifier.
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_J     = 8'h6A;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_UC_D  = 8'h44;
  localparam logic [7:0] CH_UC_O  = 8'h4F;
  localparam logic [7:0] CH_UC_U  = 8'h55;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_O  = 8'h6F;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_LC_X  = 8'h78;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_DOT,
    MODE_WIDTH,
    MODE_PREC
  } scan_mode_t;

  typedef enum logic [2:0] {
    MOD_NONE,
    MOD_H,
    MOD_L,
    MOD_J,
    MOD_Z
  } mod_code_t;

  typedef enum logic [1:0] {
    ZP_NONE,
    ZP_ZERO,
    ZP_NONZERO
  } zero_mark_t;

  typedef struct packed {
    logic space;
    logic hash;
    logic minus;
    logic plus;
  } sign_flags_t;

  typedef struct packed {
    logic               prev_dot;
    scan_mode_t         mode;
    logic [30:0]        width_acc;
    logic signed [31:0] precision_acc;
    sign_flags_t        flags;
    zero_mark_t         zero_mark;
    mod_code_t          mod_first;
    mod_code_t          mod_second;
    logic [15:0]        char_count;
  } spec_state_t;

  localparam spec_state_t ST_RESET = '{
    prev_dot:      1'b0,
    mode:          MODE_NORMAL,
    width_acc:     31'd0,
    precision_acc: 32'sd0,
    flags:         '0,
    zero_mark:     ZP_NONE,
    mod_first:     MOD_NONE,
    mod_second:    MOD_NONE,
    char_count:    16'd0
  };

  typedef struct packed {
    logic [7:0]         conversion;
    logic [30:0]        width;
    logic signed [31:0] precision;
    logic               flag_plus;
    logic               flag_minus;
    logic               flag_hash;
    logic               flag_space;
    logic [1:0]         zero_pad;
    logic [2:0]         length_mod;
    logic [1:0]         length_doubled;
    logic [15:0]        spec_length;
  } spec_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_spec_char(input logic [7:0] c);
    return is_digit(c) || c == CH_SPACE || c == CH_STAR || c == CH_HASH ||
           c == CH_PLUS || c == CH_MINUS || c == CH_DOT || c == CH_H ||
           c == CH_L || c == CH_J || c == CH_Z;
  endfunction

  function automatic mod_code_t mod_code_of(input logic [7:0] c);
    mod_code_t m;
    case (c)
      CH_H:    m = MOD_H;
      CH_L:    m = MOD_L;
      CH_J:    m = MOD_J;
      CH_Z:    m = MOD_Z;
      default: m = MOD_NONE;
    endcase
    return m;
  endfunction

  // Multiply by ten and add one decimal digit, saturating at SAT31.
  function automatic logic [30:0] acc_dec_sat(input logic [30:0] v, input logic [3:0] d);
    logic [34:0] t;
    t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {31'b0, d};
    return (t > {4'b0, SAT31}) ? SAT31 : t[30:0];
  endfunction

endpackage

[rtl/fsp_if.sv]
// Channel interfaces for the format specifier parser: character beats in, results out.
// Stand-alone; the payload fields match the widths used in fsp_pkg.
interface fsp_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         ch;
  logic               start_req;
  logic signed [31:0] star_value;

  modport source (output valid, ch, start_req, star_value, input ready);
  modport sink   (input valid, ch, start_req, star_value, output ready);
endinterface

interface fsp_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         conversion;
  logic [30:0]        width;
  logic signed [31:0] precision;
  logic               flag_plus;
  logic               flag_minus;
  logic               flag_hash;
  logic               flag_space;
  logic [1:0]         zero_pad;
  logic [2:0]         length_mod;
  logic [1:0]         length_doubled;
  logic [15:0]        spec_length;

  modport source (output valid, conversion, width, precision, flag_plus, flag_minus,
                  flag_hash, flag_space, zero_pad, length_mod, length_doubled,
                  spec_length, input ready);
  modport sink   (input valid, conversion, width, precision, flag_plus, flag_minus,
                  flag_hash, flag_space, zero_pad, length_mod, length_doubled,
                  spec_length, output ready);
endinterface

[rtl/fsp_step.sv]
// Per-character decision logic: next parser state and the result of a terminating character.
// Depends on fsp_pkg.
module fsp_step (
  input  logic [7:0]           ch,
  input  logic                 start_req,
  input  logic signed [31:0]   star_value,
  input  fsp_pkg::spec_state_t st,
  output fsp_pkg::spec_state_t st_next,
  output logic                 term,
  output fsp_pkg::spec_result_t res
);

  fsp_pkg::spec_state_t cur;
  fsp_pkg::mod_code_t   code;
  logic [3:0]           digit;
  logic                 neg;
  logic [31:0]          mag;
  logic [30:0]          mag_sat;
  logic                 cancel_prec_set;
  logic                 cancel_int_set;
  logic [1:0]           zp;

  always_comb begin
    cur     = start_req ? fsp_pkg::ST_RESET : st;
    code    = fsp_pkg::mod_code_of(ch);
    digit   = ch[3:0];
    neg     = star_value[31];
    mag     = neg ? (~star_value + 32'd1) : star_value;
    mag_sat = mag[31] ? fsp_pkg::SAT31 : mag[30:0];
    term    = !fsp_pkg::is_spec_char(ch);

    cancel_prec_set = ch == fsp_pkg::CH_LC_D || ch == fsp_pkg::CH_UC_D ||
                      ch == fsp_pkg::CH_LC_I || ch == fsp_pkg::CH_LC_O ||
                      ch == fsp_pkg::CH_UC_O || ch == fsp_pkg::CH_LC_X ||
                      ch == fsp_pkg::CH_UC_X;
    cancel_int_set  = cancel_prec_set || ch == fsp_pkg::CH_LC_U || ch == fsp_pkg::CH_UC_U;

    zp = cur.zero_mark;
    if (cancel_prec_set && cur.precision_acc == -32'sd1) begin
      zp = fsp_pkg::ZP_NONE;
    end
    if (cancel_int_set && (cur.flags.minus || cur.precision_acc > 32'sd0)) begin
      zp = fsp_pkg::ZP_NONE;
    end

    res.conversion     = ch;
    res.width          = cur.width_acc;
    res.precision      = cur.precision_acc;
    res.flag_plus      = cur.flags.plus;
    res.flag_minus     = cur.flags.minus;
    res.flag_hash      = cur.flags.hash;
    res.flag_space     = cur.flags.space;
    res.zero_pad       = zp;
    res.length_mod     = cur.mod_first;
    // A doubled modifier only survives if the final modifier is the same letter.
    res.length_doubled = (cur.mod_first == cur.mod_second) ? cur.mod_second[1:0] : 2'd0;
    res.spec_length    = cur.char_count;

    st_next = cur;
    if (term) begin
      st_next = fsp_pkg::ST_RESET;
    end else begin
      if (fsp_pkg::is_digit(ch)) begin
        case (cur.mode)
          fsp_pkg::MODE_PREC: begin
            st_next.precision_acc =
              {1'b0, fsp_pkg::acc_dec_sat(cur.precision_acc[30:0], digit)};
          end
          fsp_pkg::MODE_WIDTH: begin
            st_next.width_acc = fsp_pkg::acc_dec_sat(cur.width_acc, digit);
          end
          default: begin
            if (cur.mode == fsp_pkg::MODE_DOT && digit != 4'd0) begin
              st_next.precision_acc = {28'd0, digit};
              st_next.mode          = fsp_pkg::MODE_PREC;
            end else begin
              if (cur.zero_mark == fsp_pkg::ZP_NONE) begin
                st_next.zero_mark = (digit != 4'd0) ? fsp_pkg::ZP_NONZERO : fsp_pkg::ZP_ZERO;
              end
              if (cur.mode == fsp_pkg::MODE_DOT) begin
                st_next.mode = fsp_pkg::MODE_NORMAL;
              end else begin
                st_next.width_acc = {27'd0, digit};
                st_next.mode      = fsp_pkg::MODE_WIDTH;
              end
            end
          end
        endcase
      end else if (ch == fsp_pkg::CH_DOT) begin
        st_next.precision_acc = -32'sd1;
        st_next.mode          = fsp_pkg::MODE_DOT;
      end else begin
        st_next.mode = fsp_pkg::MODE_NORMAL;
        if (ch == fsp_pkg::CH_PLUS)  st_next.flags.plus  = 1'b1;
        if (ch == fsp_pkg::CH_MINUS) st_next.flags.minus = 1'b1;
        if (ch == fsp_pkg::CH_HASH)  st_next.flags.hash  = 1'b1;
        if (ch == fsp_pkg::CH_SPACE) st_next.flags.space = 1'b1;
        if (cur.mod_second == fsp_pkg::MOD_NONE && cur.mod_first != fsp_pkg::MOD_NONE &&
            (ch == fsp_pkg::CH_H || ch == fsp_pkg::CH_L) && code == cur.mod_first) begin
          st_next.mod_second = code;
        end
        if ((cur.mod_first == fsp_pkg::MOD_NONE || ch == fsp_pkg::CH_L) &&
            code != fsp_pkg::MOD_NONE) begin
          st_next.mod_first = code;
        end
        if (ch == fsp_pkg::CH_STAR) begin
          if (cur.prev_dot) begin
            if (neg) begin
              st_next.precision_acc = 32'sd0;
            end else if (star_value == 32'sd0) begin
              st_next.precision_acc = -32'sd1;
            end else begin
              st_next.precision_acc = star_value;
            end
          end else begin
            if (neg) st_next.flags.minus = 1'b1;
            st_next.width_acc = mag_sat;
          end
        end
      end
      st_next.prev_dot = (ch == fsp_pkg::CH_DOT);
      if (cur.char_count != fsp_pkg::CNT_MAX) begin
        st_next.char_count = cur.char_count + 16'd1;
      end
    end
  end

endmodule

[rtl/format_specifier_parser.sv]
// Top level of the format specifier parser: input register, parser state and result register.
// Depends on fsp_pkg, fsp_if.sv (fsp_in_if, fsp_out_if) and fsp_step.
//
// The parser takes one character beat per clock cycle from the text that follows a percent
// sign and keeps the specifier being built (flags, width, precision, length modifier and the
// count of characters taken). A beat with start_req set discards anything partly built before
// its character is looked at. Any character outside the specifier set, NUL included, ends the
// specifier and yields exactly one result beat carrying that character as the conversion
// letter; all other characters yield nothing. Each character waits in the input register and
// is folded into the parser state as it leaves it, so while no stall holds it the sustained
// rate is one character per cycle. A terminating character's result beat is written to the
// result register as that character leaves the input register. The only stall comes from
// the result register: a terminating character waits in the input register while an earlier
// result has not yet been taken, and input ready then follows the output side's ready within
// the same cycle. Width and precision saturate at 2147483647, the character count at 65535.
module format_specifier_parser (
  input  logic            clk,
  input  logic            rst,
  fsp_in_if.sink          spec_in,
  fsp_out_if.source       spec_out
);

  // Input register stage.
  logic               s1_valid;
  logic [7:0]         s1_ch;
  logic               s1_start;
  logic signed [31:0] s1_star;

  // Parser state and result register.
  fsp_pkg::spec_state_t  st;
  fsp_pkg::spec_state_t  st_next;
  fsp_pkg::spec_result_t step_res;
  fsp_pkg::spec_result_t out_res;
  logic                  step_term;
  logic                  out_valid;
  logic                  s1_fire;

  fsp_step u_step (
    .ch         (s1_ch),
    .start_req  (s1_start),
    .star_value (s1_star),
    .st         (st),
    .st_next    (st_next),
    .term       (step_term),
    .res        (step_res)
  );

  // A character that produces no result never needs the result register.
  assign s1_fire       = s1_valid && (!step_term || !out_valid || spec_out.ready);
  assign spec_in.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (spec_in.ready) begin
      s1_valid <= spec_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (spec_in.valid && spec_in.ready) begin
      s1_ch    <= spec_in.ch;
      s1_start <= spec_in.start_req;
      s1_star  <= spec_in.star_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= fsp_pkg::ST_RESET;
    end else if (s1_fire) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && step_term) begin
      out_valid <= 1'b1;
    end else if (spec_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && step_term) begin
      out_res <= step_res;
    end
  end

  assign spec_out.valid          = out_valid;
  assign spec_out.conversion     = out_res.conversion;
  assign spec_out.width          = out_res.width;
  assign spec_out.precision      = out_res.precision;
  assign spec_out.flag_plus      = out_res.flag_plus;
  assign spec_out.flag_minus     = out_res.flag_minus;
  assign spec_out.flag_hash      = out_res.flag_hash;
  assign spec_out.flag_space     = out_res.flag_space;
  assign spec_out.zero_pad       = out_res.zero_pad;
  assign spec_out.length_mod     = out_res.length_mod;
  assign spec_out.length_doubled = out_res.length_doubled;
  assign spec_out.spec_length    = out_res.spec_length;

  // A terminating character leaves the parser in its cleared state.
  a_clear_after_term: assert property (@(posedge clk) disable iff (rst)
    s1_fire && step_term |=> st.char_count == 16'd0 && !st.prev_dot &&
                             st.mode == fsp_pkg::MODE_NORMAL)
    else $error("parser state not cleared after a terminating character");

  // Inside a precision digit run the accumulated precision is always positive.
  a_prec_positive: assert property (@(posedge clk) disable iff (rst)
    st.mode == fsp_pkg::MODE_PREC |-> st.precision_acc > 32'sd0)
    else $error("precision run with non-positive precision");

  // A result never carries a digit or a dot as its conversion letter.
  a_conv_not_spec: assert property (@(posedge clk) disable iff (rst)
    spec_out.valid |-> !(spec_out.conversion >= fsp_pkg::CH_ZERO &&
                         spec_out.conversion <= fsp_pkg::CH_NINE) &&
                       spec_out.conversion != fsp_pkg::CH_DOT)
    else $error("result beat with a specifier character as conversion");

  // Result codes stay within their defined ranges.
  a_codes_range: assert property (@(posedge clk) disable iff (rst)
    spec_out.valid |-> spec_out.zero_pad != 2'd3 && spec_out.length_mod <= 3'd4 &&
                       spec_out.length_doubled != 2'd3)
    else $error("result beat with an undefined code");

endmodule

[verif/format_specifier_parser_checker.sv]
`timescale 1ns / 1ps
// Checker for the format specifier parser: watches both channels, predicts each result
// from the accepted character beats and compares it field by field. Depends on fsp_pkg.
module format_specifier_parser_checker (
  input  logic clk,
  input  logic rst,
  fsp_in_if    spec_in,
  fsp_out_if   spec_out,
  output int   fail_count,
  output int   open_count,
  output int   checked_count
);
  import fsp_pkg::*;

  // Predicted parser state.
  logic               after_dot;
  scan_mode_t         mode;
  logic [30:0]        width_acc;
  logic signed [31:0] prec_acc;
  sign_flags_t        flags;
  zero_mark_t         zmark;
  mod_code_t          mod_first;
  mod_code_t          mod_second;
  logic [15:0]        taken;

  spec_result_t pending_specs[$];
  int fails = 0;
  int checks = 0;

  task automatic clear_spec();
    after_dot  = 1'b0;
    mode       = MODE_NORMAL;
    width_acc  = '0;
    prec_acc   = '0;
    flags      = '0;
    zmark      = ZP_NONE;
    mod_first  = MOD_NONE;
    mod_second = MOD_NONE;
    taken      = '0;
  endtask

  // Folds one character into the predicted state; a terminator queues the expected result.
  task automatic parse_char(input logic [7:0] c, input logic st, input logic [31:0] sv);
    logic         is_term;
    logic         dot_cancel;
    logic         int_cancel;
    logic [3:0]   d;
    logic [63:0]  acc;
    logic [31:0]  mag;
    mod_code_t    code;
    spec_result_t r;
    if (st) clear_spec();
    case (c)
      CH_SPACE, CH_STAR, CH_HASH, CH_PLUS, CH_MINUS, CH_DOT, CH_H, CH_L, CH_J, CH_Z:
        is_term = 1'b0;
      default: is_term = !(c >= CH_ZERO && c <= CH_NINE);
    endcase
    case (c)
      CH_LC_D, CH_UC_D, CH_LC_I, CH_LC_O, CH_UC_O, CH_LC_X, CH_UC_X: dot_cancel = 1'b1;
      default: dot_cancel = 1'b0;
    endcase
    int_cancel = dot_cancel || c == CH_LC_U || c == CH_UC_U;

    if (is_term) begin
      r.conversion = c;
      r.width      = width_acc;
      r.precision  = prec_acc;
      r.flag_plus  = flags.plus;
      r.flag_minus = flags.minus;
      r.flag_hash  = flags.hash;
      r.flag_space = flags.space;
      r.zero_pad   = zmark;
      if (dot_cancel && prec_acc == -1) r.zero_pad = ZP_NONE;
      if (int_cancel && (flags.minus || prec_acc > 0)) r.zero_pad = ZP_NONE;
      r.length_mod     = mod_first;
      r.length_doubled = (mod_first == mod_second) ? 2'(mod_second) : 2'd0;
      r.spec_length    = taken;
      pending_specs.push_back(r);
      clear_spec();
    end else begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = c[3:0];  // ASCII digits carry their value in the low nibble
        if (mode == MODE_PREC) begin
          acc = 64'(prec_acc[31:0]) * 64'd10 + 64'(d);
          prec_acc = (acc > 64'(SAT31)) ? {1'b0, SAT31} : acc[31:0];
        end else if (mode == MODE_WIDTH) begin
          acc = 64'(width_acc) * 64'd10 + 64'(d);
          width_acc = (acc > 64'(SAT31)) ? SAT31 : acc[30:0];
        end else if (mode == MODE_DOT && d != 0) begin
          prec_acc = 32'(d);
          mode = MODE_PREC;
        end else begin
          if (zmark == ZP_NONE) zmark = (d != 0) ? ZP_NONZERO : ZP_ZERO;
          // A zero right after the dot only marks zero padding; width stays as it was.
          if (mode == MODE_DOT) begin
            mode = MODE_NORMAL;
          end else begin
            width_acc = 31'(d);
            mode = MODE_WIDTH;
          end
        end
      end else if (c == CH_DOT) begin
        prec_acc = -1;
        mode = MODE_DOT;
      end else begin
        case (c)
          CH_H:    code = MOD_H;
          CH_L:    code = MOD_L;
          CH_J:    code = MOD_J;
          CH_Z:    code = MOD_Z;
          default: code = MOD_NONE;
        endcase
        mode = MODE_NORMAL;
        if (c == CH_PLUS)  flags.plus  = 1'b1;
        if (c == CH_MINUS) flags.minus = 1'b1;
        if (c == CH_HASH)  flags.hash  = 1'b1;
        if (c == CH_SPACE) flags.space = 1'b1;
        if (mod_second == MOD_NONE && mod_first != MOD_NONE && (c == CH_H || c == CH_L) &&
            code == mod_first)
          mod_second = code;
        if ((mod_first == MOD_NONE || c == CH_L) && code != MOD_NONE) mod_first = code;
        if (c == CH_STAR) begin
          mag = sv[31] ? (~sv + 32'd1) : sv;
          if (mag > {1'b0, SAT31}) mag = {1'b0, SAT31};
          if (after_dot) begin
            if (sv[31])       prec_acc = 0;
            else if (sv == 0) prec_acc = -1;
            else              prec_acc = mag;
          end else begin
            if (sv[31]) flags.minus = 1'b1;
            width_acc = mag[30:0];
          end
        end
      end
      after_dot = (c == CH_DOT);
      if (taken != CNT_MAX) taken++;
    end
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : watch
    spec_result_t want;
    if (rst) begin
      clear_spec();
      pending_specs.delete();
    end else begin
      if (spec_in.valid && spec_in.ready)
        parse_char(spec_in.ch, spec_in.start_req, spec_in.star_value);
      if (spec_out.valid && spec_out.ready) begin
        if (pending_specs.size() == 0) begin
          $error("result beat with conversion %0d arrived while none was expected",
                 spec_out.conversion);
          fails++;
        end else begin
          want = pending_specs.pop_front();
          checks++;
          check_field("conversion", want.conversion, spec_out.conversion);
          check_field("width", want.width, spec_out.width);
          check_field("precision", want.precision, $signed(spec_out.precision));
          check_field("flag_plus", want.flag_plus, spec_out.flag_plus);
          check_field("flag_minus", want.flag_minus, spec_out.flag_minus);
          check_field("flag_hash", want.flag_hash, spec_out.flag_hash);
          check_field("flag_space", want.flag_space, spec_out.flag_space);
          check_field("zero_pad", want.zero_pad, spec_out.zero_pad);
          check_field("length_mod", want.length_mod, spec_out.length_mod);
          check_field("length_doubled", want.length_doubled, spec_out.length_doubled);
          check_field("spec_length", want.spec_length, spec_out.spec_length);
        end
      end
    end
    fail_count    <= fails;
    open_count    <= pending_specs.size();
    checked_count <= checks;
  end

endmodule

[verif/format_specifier_parser_test.sv]
`timescale 1ns / 1ps
// Top of the format specifier parser testbench: clock, reset, character stimulus and verdict.
// Depends on fsp_pkg, the channel interfaces, the block and format_specifier_parser_checker.
module format_specifier_parser_test;
  import fsp_pkg::*;

  localparam int RANDOM_CHARS = 830;
  localparam int CALM_AFTER   = 720;      // no idling on either side past this point
  localparam int LONG_RUN     = 40;       // one long specifier mixing every specifier character
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk;
  logic rst;
  bit   calm = 1'b0;
  int   chars_sent = 0;
  int   cycles = 0;
  int   fail_count;
  int   open_count;
  int   checked_count;

  // Characters of the specifier being assembled, and the values its stars will carry.
  logic [7:0]  spec_chars[$];
  logic [31:0] star_vals[$];

  fsp_in_if  spec_in ();
  fsp_out_if spec_out ();

  format_specifier_parser dut (
    .clk      (clk),
    .rst      (rst),
    .spec_in  (spec_in),
    .spec_out (spec_out)
  );

  format_specifier_parser_checker spec_check (
    .clk           (clk),
    .rst           (rst),
    .spec_in       (spec_in),
    .spec_out      (spec_out),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: ready drops in random bursts, separated by random stretches where it stays
  // high. Once calm is set it stays high.
  initial begin
    spec_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        spec_out.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      spec_out.ready <= 1'b1;
      repeat ($urandom_range(0, 24)) @(posedge clk);
    end
  end

  // Offers one character beat and returns at the edge that accepts it. Afterwards the sender
  // may go quiet for a random burst; the payload is scrambled while valid is low so that
  // the block is seen to ignore anything it has not accepted.
  task automatic put_char(input logic [7:0] c, input logic st, input logic [31:0] sv);
    spec_in.valid      <= 1'b1;
    spec_in.ch         <= c;
    spec_in.start_req  <= st;
    spec_in.star_value <= sv;
    do @(posedge clk); while (!spec_in.ready);
    chars_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      spec_in.valid      <= 1'b0;
      spec_in.ch         <= 8'($urandom);
      spec_in.start_req  <= 1'($urandom);
      spec_in.star_value <= $urandom;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Stops sending and waits until the checker holds no outstanding expectation.
  task automatic drain();
    spec_in.valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  // Star arguments lean toward the interesting values: zero, small magnitudes of either
  // sign and both ends of the 32-bit range; the rest are fully random.
  function automatic logic [31:0] pick_star();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'($urandom_range(1, 99));
      2:       return -32'($urandom_range(1, 99));
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Sends the assembled characters. Directed specifiers always begin with start_req set;
  // random ones set it on their first character half the time (the parser is already clean
  // after a terminator) and now and then in the middle, which throws away the partial one.
  // Characters that are not stars still carry random star values.
  task automatic send_queue(input bit directed);
    logic st;
    logic [31:0] sv;
    for (int i = 0; i < spec_chars.size(); i++) begin
      if (i == 0) st = directed ? 1'b1 : 1'($urandom_range(0, 1));
      else        st = !directed && $urandom_range(0, 49) == 0;
      if (spec_chars[i] == CH_STAR && star_vals.size() != 0) sv = star_vals.pop_front();
      else sv = $urandom;
      put_char(spec_chars[i], st, sv);
    end
    spec_chars.delete();
    star_vals.delete();
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) spec_chars.push_back(s[i]);
    send_queue(1'b1);
  endtask

  task automatic add_digits(input int n);
    repeat (n) spec_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Builds one random specifier. Most are well formed with random content: flags, then a
  // width (digits, a long run that may saturate, a leading zero or a star), then maybe a
  // precision, a length modifier and a conversion letter. One in ten is pure byte noise and
  // one in ten has a byte overwritten somewhere.
  task automatic random_spec();
    string flag_set = "+- #0";
    string mod_set  = "hljz";
    string conv_set = "diouxXDOUcspn%";
    int kind;
    int sel;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) spec_chars.push_back(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 3)) spec_chars.push_back(flag_set[$urandom_range(0, 4)]);

      case ($urandom_range(0, 9))
        3, 4, 5, 6: add_digits($urandom_range(1, 3));
        7: begin
          spec_chars.push_back(CH_STAR);
          star_vals.push_back(pick_star());
        end
        8: add_digits($urandom_range(10, 12));
        9: begin
          spec_chars.push_back(CH_ZERO);
          add_digits($urandom_range(1, 2));
        end
        default: ;
      endcase

      sel = $urandom_range(0, 7);
      if (sel >= 3) spec_chars.push_back(CH_DOT);
      case (sel)
        4: add_digits($urandom_range(1, 3));
        5: begin
          spec_chars.push_back(CH_STAR);
          star_vals.push_back(pick_star());
        end
        6: add_digits($urandom_range(10, 11));
        7: begin
          spec_chars.push_back(CH_ZERO);
          add_digits($urandom_range(1, 2));
        end
        default: ;
      endcase

      sel = $urandom_range(0, 5);
      if (sel >= 4) begin
        // Doubled h or l, sometimes followed by another modifier that may undo the doubling.
        spec_chars.push_back(sel == 4 ? CH_H : CH_L);
        spec_chars.push_back(sel == 4 ? CH_H : CH_L);
        if ($urandom_range(0, 2) == 0) spec_chars.push_back(mod_set[$urandom_range(0, 3)]);
      end else if (sel >= 2) begin
        repeat (sel - 1) spec_chars.push_back(mod_set[$urandom_range(0, 3)]);
      end

      sel = $urandom_range(0, 9);
      if (sel <= 5)      spec_chars.push_back(conv_set[$urandom_range(0, 13)]);
      else if (sel == 6) spec_chars.push_back(8'h00);
      else               spec_chars.push_back(8'($urandom_range(0, 255)));

      if (kind == 1)
        spec_chars[$urandom_range(0, spec_chars.size() - 1)] = 8'($urandom_range(0, 255));
    end
    send_queue(1'b0);
  endtask

  initial begin : stimulus
    string long_set = "0123456789 +-#hljz.*";
    int random_base;
    bit paused;
    rst                <= 1'b1;
    spec_in.valid      <= 1'b0;
    spec_in.ch         <= '0;
    spec_in.start_req  <= 1'b0;
    spec_in.star_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. All four flags ahead of a hex conversion.
    send_text("# +-x");
    // Zero padding with a dot and no digits: precision -1 cancels the zero for d.
    send_text("05.d");
    // Width star at the most negative value saturates and sets minus; a negative
    // precision star gives precision 0; hh is kept as doubled.
    star_vals.push_back(32'h8000_0000);
    star_vals.push_back(-32'd5);
    send_text("*.*hhi");
    // Precision star of zero gives -1; a later l overrides z.
    star_vals.push_back(32'd0);
    send_text(".*zlu");
    // The minus flag cancels zero padding for an integer conversion.
    send_text("-0o");
    // A zero right after the dot only marks zero padding and the 3 starts a new width.
    send_text(".03u");
    // hh followed by l drops the doubling; the string ends with NUL as terminator.
    send_text("hhl");
    put_char(8'h00, 1'b0, $urandom);
    // A lone terminator with the top bit set gives an empty specifier.
    put_char(8'hFF, 1'b1, $urandom);

    // The sender holds off here until every expected result has come back.
    drain();

    // One long specifier that mixes every specifier character; no sender gaps.
    calm = 1'b1;
    for (int i = 0; i < LONG_RUN; i++)
      put_char(long_set[$urandom_range(0, 19)], i == 0, pick_star());
    put_char(CH_LC_D, 1'b0, $urandom);
    calm = 1'b0;
    drain();

    // Random part, with one more full pause about half way through.
    random_base = chars_sent;
    paused = 1'b0;
    while (chars_sent - random_base < RANDOM_CHARS) begin
      if (chars_sent - random_base >= CALM_AFTER) calm = 1'b1;
      random_spec();
      if (!paused && chars_sent - random_base >= RANDOM_CHARS / 2) begin
        drain();
        paused = 1'b1;
      end
    end

    // Let everything arrive, then keep watching for any stray result beat before the verdict.
    drain();
    repeat (8) @(posedge clk);

    $display("Sent %0d format characters: directed specifiers, one %0d-character specifier,",
             chars_sent, LONG_RUN + 1);
    $display("and random streams with noise; %0d result beats were compared.", checked_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/fsp_pkg.sv
rtl/fsp_if.sv
rtl/fsp_step.sv
rtl/format_specifier_parser.sv
verif/format_specifier_parser_checker.sv
verif/format_specifier_parser_test.sv
